// ----- hw/rtl/ttlb_pkg.sv -----
`default_nettype none
package ttlb_pkg;

   localparam int ROWS = 64;
   localparam int COLS = 160;

   localparam int ROW_W  = 6;
   localparam int COL_W  = 8;
   localparam int CH_W   = 8;
   localparam int ADDR_W = $clog2(ROWS * COLS);

   localparam logic [CH_W-1:0] CH_CR          = 8'h0D;
   localparam logic [CH_W-1:0] CH_LF          = 8'h0A;
   localparam logic [CH_W-1:0] CH_BS          = 8'h08;
   localparam logic [CH_W-1:0] CH_DEL         = 8'h7F;
   localparam logic [CH_W-1:0] CH_FIRST_PRINT = 8'd32;
   localparam logic [CH_W-1:0] CH_LAST_PRINT  = 8'd126;

   localparam logic [2:0] OP_NOP  = 3'd0;
   localparam logic [2:0] OP_READ = 3'd1;
   localparam logic [2:0] OP_CR   = 3'd2;
   localparam logic [2:0] OP_LF   = 3'd3;
   localparam logic [2:0] OP_BS   = 3'd4;
   localparam logic [2:0] OP_PUT  = 3'd5;

   typedef struct packed {
      logic [2:0]       op;
      logic [CH_W-1:0]  ch;
      logic [ROW_W-1:0] rrow;
      logic [COL_W-1:0] rcol;
   } op_type;

   typedef struct packed {
      logic pop;
      logic init;
   } back_stat_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ttlb_front.sv -----
`default_nettype none
module ttlb_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_mode,
   input  wire logic [ttlb_pkg::CH_W-1:0]      req_char_code,
   input  wire logic [ttlb_pkg::ROW_W-1:0]     req_read_row,
   input  wire logic [ttlb_pkg::COL_W-1:0]     req_read_col,
   output logic                                op_valid,
   output ttlb_pkg::op_type                    op,
   input  wire ttlb_pkg::back_stat_type        stat
);

   localparam int QDEPTH = 2;

   ttlb_pkg::op_type    cls;
   ttlb_pkg::op_type    q_ff [QDEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                push;

   always_comb begin
      cls.ch   = req_char_code;
      cls.rrow = req_read_row;
      cls.rcol = req_read_col;
      if (req_mode) begin
         if (int'(req_read_row) < ttlb_pkg::ROWS && int'(req_read_col) < ttlb_pkg::COLS)
            cls.op = ttlb_pkg::OP_READ;
         else
            cls.op = ttlb_pkg::OP_NOP;
      end else begin
         case (req_char_code)
            ttlb_pkg::CH_CR:                  cls.op = ttlb_pkg::OP_CR;
            ttlb_pkg::CH_LF:                  cls.op = ttlb_pkg::OP_LF;
            ttlb_pkg::CH_BS, ttlb_pkg::CH_DEL: cls.op = ttlb_pkg::OP_BS;
            default: begin
               if (req_char_code inside {[ttlb_pkg::CH_FIRST_PRINT:ttlb_pkg::CH_LAST_PRINT]})
                  cls.op = ttlb_pkg::OP_PUT;
               else
                  cls.op = ttlb_pkg::OP_NOP;
            end
         endcase
      end
   end

   assign busy     = (cnt_ff == 2'(QDEPTH)) || stat.init;
   assign push     = start && !busy;
   assign op_valid = (cnt_ff != 2'd0);
   assign op       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = stat.pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(stat.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         q_ff[wr_ptr_ff] <= cls;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ttlb_back.sv -----
`default_nettype none
module ttlb_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           op_valid,
   input  wire ttlb_pkg::op_type               op,
   output ttlb_pkg::back_stat_type             stat,
   output logic                                rsp_strobe,
   output logic [ttlb_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [ttlb_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic                                rsp_scrolled,
   output logic [ttlb_pkg::CH_W-1:0]           rsp_cell_value
);

   localparam int ROW_W  = ttlb_pkg::ROW_W;
   localparam int COL_W  = ttlb_pkg::COL_W;
   localparam int CH_W   = ttlb_pkg::CH_W;
   localparam int ADDR_W = ttlb_pkg::ADDR_W;

   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_READ    = 3'd2;
   localparam logic [2:0] ST_SCROLL  = 3'd3;
   localparam logic [2:0] ST_PUT     = 3'd4;
   localparam logic [2:0] ST_CLRNEXT = 3'd5;

   localparam logic [ROW_W:0]    ROWS_X   = (ROW_W+1)'(ttlb_pkg::ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ttlb_pkg::ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(ttlb_pkg::COLS - 1);
   localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(ttlb_pkg::COLS);
   localparam logic [ADDR_W-1:0] LAST_SWP = ADDR_W'(ttlb_pkg::COLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(ttlb_pkg::ROWS * ttlb_pkg::COLS - 1);

   logic [CH_W-1:0]   mem [ttlb_pkg::ROWS * ttlb_pkg::COLS];

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [CH_W-1:0]   pend_ch_ff, pend_ch_in;
   logic              pend_put_ff, pend_put_in;
   logic              scr_ff, scr_in;
   logic [CH_W-1:0]   rd_ff;

   logic              strobe_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic              rsp_scr_ff;
   logic [CH_W-1:0]   rsp_cell_ff;

   logic              emit;
   logic [CH_W-1:0]   cell_sel;
   logic              pop;
   logic              we;
   logic [CH_W-1:0]   wdata;
   logic              lin;
   logic [ROW_W-1:0]  lrow;
   logic [COL_W-1:0]  lcol;
   logic [ROW_W:0]    psum;
   logic [ROW_W:0]    prow;
   logic [ADDR_W-1:0] addr;

   always_comb begin
      psum = {1'b0, top_ff} + {1'b0, lrow};
      prow = (psum >= ROWS_X) ? psum - ROWS_X : psum;
      if (lin)
         addr = sweep_ff;
      else
         addr = ADDR_W'(prow[ROW_W-1:0]) * COLS_A + ADDR_W'(lcol);
   end

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      top_in      = top_ff;
      sweep_in    = sweep_ff;
      pend_ch_in  = pend_ch_ff;
      pend_put_in = pend_put_ff;
      scr_in      = scr_ff;
      emit        = 1'b0;
      cell_sel    = '0;
      pop         = 1'b0;
      we          = 1'b0;
      wdata       = '0;
      lin         = 1'b0;
      lrow        = row_ff;
      lcol        = col_ff;
      case (state_ff)
         ST_INIT: begin
            lin = 1'b1;
            we  = 1'b1;
            if (sweep_ff == LAST_ADR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (op_valid) begin
               pop         = 1'b1;
               scr_in      = 1'b0;
               pend_put_in = 1'b0;
               case (op.op)
                  ttlb_pkg::OP_READ: begin
                     lrow     = op.rrow;
                     lcol     = op.rcol;
                     state_in = ST_READ;
                  end
                  ttlb_pkg::OP_CR: begin
                     col_in = '0;
                     emit   = 1'b1;
                  end
                  ttlb_pkg::OP_LF: begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        sweep_in = '0;
                        scr_in   = 1'b1;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                        emit   = 1'b1;
                     end
                  end
                  ttlb_pkg::OP_BS: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                        lcol   = col_ff - 1'b1;
                        we     = 1'b1;
                     end
                     emit = 1'b1;
                  end
                  ttlb_pkg::OP_PUT: begin
                     pend_ch_in = op.ch;
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           sweep_in    = '0;
                           scr_in      = 1'b1;
                           pend_put_in = 1'b1;
                           state_in    = ST_SCROLL;
                        end else begin
                           row_in   = row_ff + 1'b1;
                           state_in = ST_PUT;
                        end
                     end else begin
                        we       = 1'b1;
                        wdata    = op.ch;
                        col_in   = col_ff + 1'b1;
                        state_in = ST_CLRNEXT;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_sel = rd_ff;
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            lrow = '0;
            lcol = sweep_ff[COL_W-1:0];
            we   = 1'b1;
            if (sweep_ff == LAST_SWP) begin
               top_in   = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
               sweep_in = '0;
               if (pend_put_ff) begin
                  state_in = ST_PUT;
               end else begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_PUT: begin
            we       = 1'b1;
            wdata    = pend_ch_ff;
            col_in   = col_ff + 1'b1;
            state_in = ST_CLRNEXT;
         end
         ST_CLRNEXT: begin
            we       = 1'b1;
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we)
         mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         row_ff      <= '0;
         col_ff      <= '0;
         top_ff      <= '0;
         sweep_ff    <= '0;
         pend_put_ff <= 1'b0;
         scr_ff      <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         top_ff      <= top_in;
         sweep_ff    <= sweep_in;
         pend_put_ff <= pend_put_in;
         scr_ff      <= scr_in;
         strobe_ff   <= emit;
      end
   end

   always_ff @(posedge clock) begin
      pend_ch_ff <= pend_ch_in;
      if (emit) begin
         rsp_row_ff  <= row_in;
         rsp_col_ff  <= col_in;
         rsp_scr_ff  <= scr_in;
         rsp_cell_ff <= cell_sel;
      end
   end

   assign stat.pop  = pop;
   assign stat.init = (state_ff == ST_INIT);

   assign rsp_strobe     = strobe_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;
   assign rsp_cell_value = rsp_cell_ff;

   a_no_beat_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !strobe_ff)
      else $error("result beat during clearing pass");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_COL)
      else $error("cursor column out of range");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> op_valid)
      else $error("pop from empty queue");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_scr_ff) |-> (rsp_row_ff == LAST_ROW))
      else $error("scroll reported off the last row");

endmodule
`default_nettype wire

// ----- hw/rtl/text_terminal_line_buffer.sv -----
`default_nettype none
// Channel   Ports                                              Handshake
// request   req_mode req_char_code req_read_row req_read_col   start & !busy
// response  rsp_cursor_row rsp_cursor_col rsp_scrolled         rsp_strobe, one cycle
//           rsp_cell_value
//
// After reset a clearing pass zeroes all ROWS*COLS (10240) store cells; busy is high.
// A two-entry queue sits between intake and execution; busy rises when it is full.
// Back end: CR, LF, BS, ignored bytes and out-of-range reads finish in ST_IDLE; reads add
// ST_READ (registered store port); printables add ST_CLRNEXT, with ST_PUT first on wrap;
// a scroll adds a line clear. The response beat is registered; no receiver stall.
module text_terminal_line_buffer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_mode,
   input  wire logic [ttlb_pkg::CH_W-1:0]      req_char_code,
   input  wire logic [ttlb_pkg::ROW_W-1:0]     req_read_row,
   input  wire logic [ttlb_pkg::COL_W-1:0]     req_read_col,
   output logic                                rsp_strobe,
   output logic [ttlb_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic [ttlb_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic                                rsp_scrolled,
   output logic [ttlb_pkg::CH_W-1:0]           rsp_cell_value
);

   logic                    op_valid;
   ttlb_pkg::op_type        op;
   ttlb_pkg::back_stat_type stat;

   ttlb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .op_valid      (op_valid),
      .op            (op),
      .stat          (stat)
   );

   ttlb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (op_valid),
      .op             (op),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_cell_value (rsp_cell_value)
   );

endmodule
`default_nettype wire
